// ===== rtl/ffra_pkg.sv =====
// package for the first-fit region allocator: sizes, entry type, status codes, states
`timescale 1ns / 1ps
`default_nettype none
package ffra_pkg;
   localparam int MAX_REGIONS = 64;
   localparam int OFFSET_BITS = 24;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int START_W     = OFFSET_BITS;
   localparam int LEN_W       = 25;
   localparam int SUM_W       = LEN_W + CNT_W;
   localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
   localparam logic [LEN_W-1:0] POOL_MAX = LEN_W'(1) << OFFSET_BITS;
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REGIONS);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } entry_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_A_RD, S_A_EV, S_R_RD, S_R_EV, S_R_DEC,
      S_D_RD, S_D_EV, S_U_RD, S_U_EV, S_W_NEW, S_FIN
   } state_type;

   function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
      logic [LEN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/first_fit_region_allocator.sv =====
// first-fit region allocator: free list in a memory, scanned and shifted by a sequencer
//
// usage
//  - req channel (valid/ready): req_type 0 allocates req_region_size elements,
//    1 releases [req_region_start, +req_region_size) back to the pool
//  - rsp channel (valid/ready): one beat per request with status, start offset
//    of an allocation and the number of pool elements in use afterwards
//  - csr port: register 0 at address 0 is total_points; writing it rebuilds the
//    free list as one region covering a nonzero pool (write only while idle)
//  - the free list lives in a 64-entry memory with registered reads;
//    each visited entry takes a read state and an evaluate state
//  - sequence: zero size or out-of-pool release goes straight to the response;
//    an allocate walks the list up to the first fit and moves the tail down
//    when an exact fit removes the entry; a release walks the list up to its
//    slot and moves the tail up on an insert, or down on a double merge; the
//    list walk runs through one memory port
//  - one request is in flight at a time; a new beat is taken once the
//    previous response has been delivered
//  - reset: pool is 2^24 elements, the S_INIT state writes the first list
//    entry and then the block is ready
//  - a stalled rsp beat holds its payload and no new request is taken
`timescale 1ns / 1ps
`default_nettype none
module first_fit_region_allocator
   import ffra_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic [LEN_W-1:0]   req_region_size,
   input  wire logic [START_W-1:0] req_region_start,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [START_W-1:0]      rsp_start_offset,
   output logic [LEN_W-1:0]        rsp_used_total,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   // free list memory
   entry_type mem [MAX_REGIONS];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;
   entry_type        wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;     // shift / alloc scan index
   logic [CNT_W-1:0]  pos_ff, pos_in;     // release insert position
   logic [CNT_W-1:0]  lim_ff, lim_in;     // list length before a removal
   logic [SUM_W-1:0]  sum_ff, sum_in;     // exact sum of free lengths
   logic [LEN_W-1:0]  total_ff, total_in;
   entry_type         prev_ff, prev_in, cur_ff, cur_in;
   logic [LEN_W-1:0]  size_ff, size_in;
   logic [START_W-1:0] rs_ff, rs_in;
   logic [1:0]        status_ff, status_in;
   logic [START_W-1:0] off_ff, off_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [START_W-1:0] rsp_start_ff, rsp_start_in;
   logic [LEN_W-1:0]  rsp_used_ff, rsp_used_in;

   logic              cfg_wr;
   logic [LEN_W-1:0]  cfg_total;
   logic [LEN_W:0]    req_end, rel_end;
   logic [LEN_W:0]    prev_end;
   logic [CNT_W-1:0]  idx_p1, pos_p1;
   logic [CNT_W:0]    idx_p2;
   logic              mn, mp;
   logic [LEN_W-1:0]  len_a, len_b, sum_sat;

   assign pready   = 1'b1;
   assign cfg_wr   = psel && penable && pwrite && (paddr == 3'd0);
   assign prdata   = (paddr == 3'd0) ? {{(32-LEN_W){1'b0}}, total_ff} : 32'd0;
   // saturate written pool size to 2^OFFSET_BITS
   assign cfg_total = (pwdata[LEN_W-1:0] > POOL_MAX) ? POOL_MAX : pwdata[LEN_W-1:0];

   assign req_ready        = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_start_offset = rsp_start_ff;
   assign rsp_used_total   = rsp_used_ff;

   assign req_end  = {1'b0, req_region_size} + {2'b0, req_region_start};
   assign rel_end  = {1'b0, size_ff} + {2'b0, rs_ff};
   assign prev_end = {2'b0, prev_ff.start} + {1'b0, prev_ff.len};
   assign idx_p1   = idx_ff + 1'b1;
   assign pos_p1   = pos_ff + 1'b1;
   assign idx_p2   = {1'b0, idx_p1} + 1'b1;
   // neighbor touches on the right / left of the released region
   assign mn = (pos_ff < count_ff) && (rel_end == {2'b0, cur_ff.start});
   assign mp = (pos_ff != '0) && (prev_end == {2'b0, rs_ff});
   assign len_a   = sat_add(prev_ff.len, size_ff);
   assign len_b   = sat_add(len_a, cur_ff.len);
   assign sum_sat = (sum_ff > SUM_W'(LEN_MAX)) ? LEN_MAX : sum_ff[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= '0;
         sum_ff       <= '0;
         total_ff     <= POOL_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= cfg_wr ? S_INIT : state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         total_ff     <= cfg_wr ? cfg_total : total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      lim_ff        <= lim_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      size_ff       <= size_in;
      rs_ff         <= rs_in;
      status_ff     <= status_in;
      off_ff        <= off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_used_ff   <= rsp_used_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      lim_in        = lim_ff;
      sum_in        = sum_ff;
      total_in      = total_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      size_in       = size_ff;
      rs_in         = rs_ff;
      status_in     = status_ff;
      off_in        = off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_used_in   = rsp_used_ff;
      rd_addr       = idx_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = rd_data_ff;

      unique case (state_ff)
         S_INIT: begin
            // one region [0, total) or an empty list
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{start: '0, len: total_ff};
            count_in = (total_ff != '0) ? CNT_W'(1) : '0;
            sum_in   = SUM_W'(total_ff);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               size_in   = req_region_size;
               rs_in     = req_region_start;
               off_in    = '0;
               idx_in    = '0;
               pos_in    = '0;
               status_in = ST_OK;
               if (req_region_size == '0) begin
                  status_in = ST_ZERO;
                  state_in  = S_FIN;
               end else if (req_type == REQ_ALLOC) begin
                  if (count_ff == '0) begin
                     status_in = ST_NOFIT;
                     state_in  = S_FIN;
                  end else begin
                     state_in = S_A_RD;
                  end
               end else if (req_end > {1'b0, total_ff}) begin
                  status_in = ST_NOFIT;
                  state_in  = S_FIN;
               end else begin
                  state_in = (count_ff == '0) ? S_R_DEC : S_R_RD;
               end
            end
         end
         S_A_RD: begin
            rd_addr  = idx_ff[IDX_W-1:0];
            state_in = S_A_EV;
         end
         S_A_EV: begin
            if (rd_data_ff.len >= size_ff) begin
               off_in = rd_data_ff.start;
               sum_in = sum_ff - SUM_W'(size_ff);
               if (rd_data_ff.len == size_ff) begin
                  // exact fit: drop the entry, pull the tail down
                  lim_in   = count_ff;
                  count_in = count_ff - 1'b1;
                  state_in = (idx_p1 < count_ff) ? S_D_RD : S_FIN;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff[IDX_W-1:0];
                  wr_data  = '{start: rd_data_ff.start + size_ff[START_W-1:0],
                               len: rd_data_ff.len - size_ff};
                  state_in = S_FIN;
               end
            end else if (idx_p1 == count_ff) begin
               status_in = ST_NOFIT;
               state_in  = S_FIN;
            end else begin
               idx_in   = idx_p1;
               state_in = S_A_RD;
            end
         end
         S_R_RD: begin
            rd_addr  = pos_ff[IDX_W-1:0];
            state_in = S_R_EV;
         end
         S_R_EV: begin
            if (rd_data_ff.start < rs_ff) begin
               prev_in  = rd_data_ff;
               pos_in   = pos_p1;
               state_in = (pos_p1 == count_ff) ? S_R_DEC : S_R_RD;
            end else begin
               cur_in   = rd_data_ff;
               state_in = S_R_DEC;
            end
         end
         S_R_DEC: begin
            idx_in = pos_ff;
            if (mp && mn) begin
               wr_en    = 1'b1;
               wr_addr  = IDX_W'(pos_ff - 1'b1);
               wr_data  = '{start: prev_ff.start, len: len_b};
               sum_in   = sum_ff + SUM_W'(len_b) - SUM_W'(prev_ff.len) - SUM_W'(cur_ff.len);
               lim_in   = count_ff;
               count_in = count_ff - 1'b1;
               state_in = (pos_p1 < count_ff) ? S_D_RD : S_FIN;
            end else if (mp) begin
               wr_en    = 1'b1;
               wr_addr  = IDX_W'(pos_ff - 1'b1);
               wr_data  = '{start: prev_ff.start, len: len_a};
               sum_in   = sum_ff + SUM_W'(len_a) - SUM_W'(prev_ff.len);
               state_in = S_FIN;
            end else if (mn) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[IDX_W-1:0];
               wr_data  = '{start: rs_ff, len: sat_add(size_ff, cur_ff.len)};
               sum_in   = sum_ff + SUM_W'(sat_add(size_ff, cur_ff.len)) - SUM_W'(cur_ff.len);
               state_in = S_FIN;
            end else if (count_ff >= CNT_MAX) begin
               status_in = ST_FULL;
               state_in  = S_FIN;
            end else begin
               // open a slot at pos by moving the tail up
               idx_in   = count_ff;
               state_in = (count_ff > pos_ff) ? S_U_RD : S_W_NEW;
            end
         end
         S_D_RD: begin
            rd_addr  = idx_p1[IDX_W-1:0];
            state_in = S_D_EV;
         end
         S_D_EV: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0];
            wr_data  = rd_data_ff;
            idx_in   = idx_p1;
            state_in = (idx_p2 < {1'b0, lim_ff}) ? S_D_RD : S_FIN;
         end
         S_U_RD: begin
            rd_addr  = IDX_W'(idx_ff - 1'b1);
            state_in = S_U_EV;
         end
         S_U_EV: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0];
            wr_data  = rd_data_ff;
            idx_in   = idx_ff - 1'b1;
            state_in = ((idx_ff - 1'b1) > pos_ff) ? S_U_RD : S_W_NEW;
         end
         S_W_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IDX_W-1:0];
            wr_data  = '{start: rs_ff, len: size_ff};
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + SUM_W'(size_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_start_in  = (status_ff == ST_OK) ? off_ff : '0;
            rsp_used_in   = (total_ff > sum_sat) ? (total_ff - sum_sat) : '0;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== verif/first_fit_region_allocator_tb.sv =====
// testbench for the first-fit region allocator: random and directed requests against a free-list model
`timescale 1ns / 1ps
module first_fit_region_allocator_tb;
   import ffra_pkg::*;

   // one expected response beat
   typedef struct packed {
      logic [1:0]         status;
      logic [START_W-1:0] offset;
      logic [LEN_W-1:0]   used;
   } alloc_rsp_type;

   // free-list model of the block plus the queue of pending response beats
   class region_scoreboard;
      logic [START_W-1:0] fr_start[MAX_REGIONS];
      logic [LEN_W-1:0]   fr_len[MAX_REGIONS];
      int                 fr_count;
      logic [LEN_W-1:0]   pool_size;
      logic [LEN_W-1:0]   free_sum;
      alloc_rsp_type      expected_rsp[$];
      int                 errors;

      function automatic logic [LEN_W-1:0] clamp_sum(longint unsigned a, longint unsigned b);
         longint unsigned s;
         s = a + b;
         return (s > LEN_MAX) ? LEN_MAX : s[LEN_W-1:0];
      endfunction

      function void recount();
         longint unsigned s;
         s = 0;
         for (int i = 0; i < fr_count; i++) s += fr_len[i];
         free_sum = (s > LEN_MAX) ? LEN_MAX : s[LEN_W-1:0];
      endfunction

      function void set_pool(longint unsigned v);
         v = v & LEN_MAX;
         if (v > POOL_MAX) v = POOL_MAX;
         pool_size = v[LEN_W-1:0];
         for (int i = 0; i < MAX_REGIONS; i++) begin
            fr_start[i] = '0;
            fr_len[i] = '0;
         end
         fr_count = (v == 0) ? 0 : 1;
         fr_len[0] = pool_size;
         recount();
      endfunction

      function void drop_entry(int k);
         for (int i = k; i + 1 < fr_count; i++) begin
            fr_start[i] = fr_start[i+1];
            fr_len[i] = fr_len[i+1];
         end
         fr_count--;
      endfunction

      function logic [1:0] take_region(logic [LEN_W-1:0] sz, output logic [START_W-1:0] off);
         off = '0;
         for (int i = 0; i < fr_count; i++) begin
            if (fr_len[i] >= sz) begin
               off = fr_start[i];
               if (fr_len[i] == sz) drop_entry(i);
               else begin
                  fr_start[i] = fr_start[i] + sz[START_W-1:0];   // wraps at offset width
                  fr_len[i] = fr_len[i] - sz;
               end
               return ST_OK;
            end
         end
         return ST_NOFIT;
      endfunction

      function logic [1:0] give_back(logic [START_W-1:0] rs, logic [LEN_W-1:0] sz);
         longint unsigned fin;
         int pos;
         bit join_prev, join_next;
         fin = longint'(rs) + sz;
         if (fin > pool_size) return ST_NOFIT;
         pos = 0;
         while (pos < fr_count && fr_start[pos] < rs) pos++;
         join_next = pos < fr_count && fin == fr_start[pos];
         join_prev = pos > 0 && (longint'(fr_start[pos-1]) + fr_len[pos-1]) == rs;
         if (join_prev && join_next) begin
            fr_len[pos-1] = clamp_sum(clamp_sum(fr_len[pos-1], sz), fr_len[pos]);
            drop_entry(pos);
         end else if (join_prev) begin
            fr_len[pos-1] = clamp_sum(fr_len[pos-1], sz);
         end else if (join_next) begin
            fr_start[pos] = rs;
            fr_len[pos] = clamp_sum(sz, fr_len[pos]);
         end else begin
            if (fr_count >= MAX_REGIONS) return ST_FULL;
            for (int i = fr_count; i > pos; i--) begin
               fr_start[i] = fr_start[i-1];
               fr_len[i] = fr_len[i-1];
            end
            fr_start[pos] = rs;
            fr_len[pos] = sz;
            fr_count++;
         end
         return ST_OK;
      endfunction

      function alloc_rsp_type note_request(logic t, logic [LEN_W-1:0] sz, logic [START_W-1:0] rs);
         alloc_rsp_type r;
         logic [START_W-1:0] off;
         off = '0;
         if (sz == 0) r.status = ST_ZERO;
         else if (t == REQ_ALLOC) r.status = take_region(sz, off);
         else r.status = give_back(rs, sz);
         r.offset = (r.status == ST_OK) ? off : '0;
         recount();
         r.used = (pool_size > free_sum) ? pool_size - free_sum : '0;
         expected_rsp.insert(expected_rsp.size(), r);
         return r;
      endfunction

      function void check_response(logic [1:0] st, logic [START_W-1:0] off, logic [LEN_W-1:0] used);
         alloc_rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (st !== e.status) begin
            $error("status expected %0d actual %0d", e.status, st);
            errors++;
         end
         if (off !== e.offset) begin
            $error("start_offset expected %0d actual %0d", e.offset, off);
            errors++;
         end
         if (used !== e.used) begin
            $error("used_total expected %0d actual %0d", e.used, used);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   wire                req_ready;
   logic               req_type = REQ_ALLOC;
   logic [LEN_W-1:0]   req_region_size = '0;
   logic [START_W-1:0] req_region_start = '0;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire [1:0]          rsp_status;
   wire [START_W-1:0]  rsp_start_offset;
   wire [LEN_W-1:0]    rsp_used_total;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   wire [31:0]         prdata;
   wire                pready;

   first_fit_region_allocator uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_region_size, .req_region_start,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_start_offset, .rsp_used_total,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #5 clock = ~clock;

   region_scoreboard sb = new();

   // regions handed out by successful allocations, candidates for release
   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   size;
   } held_region_type;
   held_region_type held[$];

   int burst_left = 0;
   int hold_left = 0;     // long receiver hold-off, counted down by the receiver
   int ready_pct = 100;

   // receiver: stall pattern that changes at random, plus the long hold-off
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pct <= 100;
            1: ready_pct <= 70;
            2: ready_pct <= 25;
            default: ready_pct <= 95;
         endcase
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   // response monitor: values are settled by the falling edge and taken at the next rise
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_start_offset, rsp_used_total);
   end

   // send one request beat, with bursts and random gaps between them
   task automatic send_req(logic t, logic [LEN_W-1:0] sz, logic [START_W-1:0] rs);
      alloc_rsp_type r;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= t;
      req_region_size <= sz;
      req_region_start <= rs;
      // wait for the beat to be accepted
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      r = sb.note_request(t, sz, rs);
      if (t == REQ_ALLOC && sz != 0 && r.status == ST_OK)
         held.insert(held.size(), held_region_type'{r.offset, sz});
   endtask

   // pause the sender until every expected beat has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);   // covers the longest list walk
   endtask

   // register write with a setup and an access phase while the block is idle, then rebuild the model
   task automatic write_pool(logic [31:0] v);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= '0;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_pool(v);
      held.delete();
   endtask

   // random request: mostly allocate/release of tracked regions, some raw noise
   task automatic random_req();
      int k, sel, cap;
      held_region_type h;
      sel = $urandom_range(0, 99);
      cap = (sb.pool_size > 8) ? sb.pool_size / 8 : 1;
      if (sel < 10) begin
         send_req(1'($urandom_range(0, 1)), LEN_W'($urandom), START_W'($urandom));
      end else if (sel < 14) begin
         send_req(1'($urandom_range(0, 1)), '0, START_W'($urandom));
      end else if (sel < 55 && held.size() != 0) begin
         k = $urandom_range(0, held.size() - 1);
         h = held[k];
         held.delete(k);
         send_req(REQ_RELEASE, h.size, h.start);
      end else begin
         send_req(REQ_ALLOC, LEN_W'($urandom_range(1, cap)), START_W'($urandom));
      end
   endtask

   initial begin
      sb.set_pool(POOL_MAX);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes on the reset pool
      send_req(REQ_ALLOC, '0, '0);                    // zero size allocate
      send_req(REQ_RELEASE, '0, 24'hFFFFFF);          // zero size release
      send_req(REQ_ALLOC, LEN_MAX, '0);               // no region fits
      send_req(REQ_ALLOC, POOL_MAX, 24'h123456);      // exact fit empties the list
      send_req(REQ_ALLOC, 25'd1, '0);                 // empty list
      send_req(REQ_RELEASE, 25'd2, 24'hFFFFFF);       // outside the pool
      send_req(REQ_RELEASE, LEN_MAX, '0);             // outside the pool
      send_req(REQ_RELEASE, 25'd16, 24'hFFFFF0);      // into an empty list
      send_req(REQ_RELEASE, 25'd16, 24'hFFFFE0);      // merge with next
      send_req(REQ_RELEASE, 25'd16, 24'h000000);      // new head
      send_req(REQ_RELEASE, 25'd16, 24'h000010);      // merge with previous
      send_req(REQ_RELEASE, POOL_MAX - 25'd64, 24'h000020); // merge both sides
      send_req(REQ_RELEASE, POOL_MAX, '0);            // overlapping release, sums saturate
      send_req(REQ_ALLOC, 25'd5, '0);
      send_req(REQ_ALLOC, POOL_MAX - 25'd1, '0);      // first fit is the second entry
      send_req(REQ_ALLOC, 25'd7, '0);

      // fragment a small pool until the region list overflows
      write_pool(32'd200);
      for (int i = 0; i < 130; i++) send_req(REQ_ALLOC, 25'd1, START_W'($urandom));
      hold_left = 400;                                // block stalls its input meanwhile
      for (int i = 0; i <= 128; i += 2) send_req(REQ_RELEASE, 25'd1, START_W'(i));
      send_req(REQ_RELEASE, 25'd1, 24'd131);          // list full
      held.delete();
      for (int i = 0; i < 60; i++) random_req();
      drain();                                        // sender waits for every result
      for (int i = 0; i < 40; i++) random_req();

      write_pool(32'd1);
      for (int i = 0; i < 30; i++) random_req();
      write_pool(32'd0);                              // empty pool
      for (int i = 0; i < 20; i++) random_req();
      write_pool(32'h01FF_FFFF);                      // saturates to full size
      for (int i = 0; i < 100; i++) random_req();
      write_pool(32'd5000);
      for (int i = 0; i < 200; i++) random_req();
      write_pool(32'd64);
      for (int i = 0; i < 100; i++) random_req();
      write_pool($urandom_range(1, 4096));
      for (int i = 0; i < 100; i++) random_req();

      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/ffra_pkg.sv
rtl/first_fit_region_allocator.sv
verif/first_fit_region_allocator_tb.sv
